@@ sv/bspg_pkg.sv @@
package bspg_pkg;

	// fixed field widths
	localparam int NUM_AXES     = 3;
	localparam int BLOCK_SLOTS  = 7;
	localparam int SLOT_W       = 3;
	localparam int SMOOTH_SHIFT = 3;
	localparam int EVENT_W      = 28;
	localparam int BLK_W        = EVENT_W + SMOOTH_SHIFT;
	localparam int STEPS_W      = 16;
	localparam int CYCLES_W     = 32;
	localparam int POS_W        = 32;
	localparam int ACC_W        = 32;
	localparam int LEVEL_W      = 2;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 32;

	localparam int RING_DEPTH_DEF = 8;

	localparam logic [STEPS_W-1:0] PERIOD_MAX = 16'hffff;

	// configuration reset values
	localparam logic [NUM_AXES-1:0] DIR_INV_RST  = 3'd0;
	localparam logic [NUM_AXES-1:0] STEP_INV_RST = 3'd7;
	localparam logic [CYCLES_W-1:0] AMASS_ONE_RST   = 32'd9000;
	localparam logic [CYCLES_W-1:0] AMASS_TWO_RST   = 32'd18000;
	localparam logic [CYCLES_W-1:0] AMASS_THREE_RST = 32'd36000;

	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_LOAD = 2'd1,
		OP_PUSH = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DIR_INV     = 3'd0,
		CFG_STEP_INV    = 3'd1,
		CFG_AMASS_ONE   = 3'd2,
		CFG_AMASS_TWO   = 3'd3,
		CFG_AMASS_THREE = 3'd4
	} cfg_idx_t;

	// one queued segment
	typedef struct packed {
		logic [STEPS_W-1:0] n_step;
		logic [STEPS_W-1:0] period;
		logic [LEVEL_W-1:0] level;
		logic [SLOT_W-1:0]  slot;
	} seg_t;

	typedef struct packed {
		logic empty;
		logic full;
	} ring_stat_t;

	// per-axis control from the tick sequencer
	typedef struct packed {
		logic go;
		logic seed;
		logic load_inc;
	} axis_ctrl_t;

endpackage

@@ sv/bresenham_step_pulse_generator_unit.sv @@
// Multi-axis step pulse generator with step smoothing.
// Input channel (in_valid / in_stall) takes one beat per command: a tick, a
// block load into a slot of the block table, or a segment push into the ring.
// Output channel (out_valid / out_stall) returns exactly one result beat per
// command, in order: step and direction bits, timer period, the period_valid,
// cycle_stop and rejected flags, and the three axis positions.
// An input beat passes the input register and then the result register on its
// way to the result beat, with all per-command work done between them.
// Throughput is one command per cycle; a new beat is taken while an earlier
// result still waits, as long as the result register can move.
// When out_stall is held the result register keeps its beat, the input
// register fills, and in_stall rises until the receiver takes the result.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at the edge;
// issue them only while no command is in flight.
// Reset clears ring pointers, axis counters, positions, pending bits and
// configuration to defaults; block table and ring contents are undefined
// until written.
module bresenham_step_pulse_generator_unit #(
	parameter int RING_DEPTH = bspg_pkg::RING_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [bspg_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bspg_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          opcode,
	input  logic [bspg_pkg::SLOT_W-1:0]         slot,
	input  logic [bspg_pkg::EVENT_W-1:0]        event_count,
	input  logic [bspg_pkg::EVENT_W-1:0]        axis_zero_steps,
	input  logic [bspg_pkg::EVENT_W-1:0]        axis_one_steps,
	input  logic [bspg_pkg::EVENT_W-1:0]        axis_two_steps,
	input  logic [bspg_pkg::NUM_AXES-1:0]       axis_dir_bits,
	input  logic [bspg_pkg::STEPS_W-1:0]        segment_steps,
	input  logic [bspg_pkg::CYCLES_W-1:0]       step_cycles,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [bspg_pkg::NUM_AXES-1:0]       step_bits,
	output logic [bspg_pkg::NUM_AXES-1:0]       dir_bits,
	output logic [bspg_pkg::STEPS_W-1:0]        timer_period,
	output logic                                period_valid,
	output logic                                cycle_stop,
	output logic                                rejected,
	output logic signed [bspg_pkg::POS_W-1:0]   position_zero,
	output logic signed [bspg_pkg::POS_W-1:0]   position_one,
	output logic signed [bspg_pkg::POS_W-1:0]   position_two
);
	import bspg_pkg::*;

	// configuration
	logic [NUM_AXES-1:0] dir_inv_q;
	logic [NUM_AXES-1:0] step_inv_q;
	logic [CYCLES_W-1:0] thr_one_q;
	logic [CYCLES_W-1:0] thr_two_q;
	logic [CYCLES_W-1:0] thr_three_q;

	// input register
	logic                           s1_valid;
	logic [1:0]                     s1_opcode;
	logic [SLOT_W-1:0]              s1_slot;
	logic [EVENT_W-1:0]             s1_event;
	logic [NUM_AXES-1:0][EVENT_W-1:0] s1_axis;
	logic [NUM_AXES-1:0]            s1_dir;
	logic [STEPS_W-1:0]             s1_steps;
	logic [CYCLES_W-1:0]            s1_cycles;

	// tick sequencer state
	logic                 running_q;
	logic [SLOT_W-1:0]    cur_slot_q;
	logic [STEPS_W-1:0]   steps_left_q;
	logic [NUM_AXES-1:0]  pend_step_q;
	logic [NUM_AXES-1:0]  pend_dir_q;

	// per-command control
	logic                 advance;
	logic                 done;
	logic                 is_tick;
	logic                 is_push;
	logic                 is_load;
	logic                 pop;
	logic                 stop;
	logic                 go;
	logic                 seed;
	logic                 seg_end;
	logic                 push_en;
	logic                 rej;
	logic [STEPS_W-1:0]   steps_cur;
	logic [STEPS_W-1:0]   steps_dec;
	logic [SLOT_W-1:0]    rd_slot;
	axis_ctrl_t           axis_ctrl;

	ring_stat_t           ring_stat;
	seg_t                 tail_seg;

	logic [BLK_W-1:0]                 blk_event;
	logic [NUM_AXES-1:0][BLK_W-1:0]   blk_axis;
	logic [NUM_AXES-1:0]              blk_dir;
	logic [NUM_AXES-1:0][BLK_W-1:0]   inc_new;
	logic [NUM_AXES-1:0]              step_raw;
	logic [NUM_AXES-1:0][POS_W-1:0]   pos_nxt;

	// handshake: result register moves when empty or taken
	assign advance  = !out_valid || !out_stall;
	assign in_stall = s1_valid && !advance;
	assign done     = s1_valid && advance;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_inv_q   <= DIR_INV_RST;
			step_inv_q  <= STEP_INV_RST;
			thr_one_q   <= AMASS_ONE_RST;
			thr_two_q   <= AMASS_TWO_RST;
			thr_three_q <= AMASS_THREE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DIR_INV:     dir_inv_q   <= cfg_data[NUM_AXES-1:0];
				CFG_STEP_INV:    step_inv_q  <= cfg_data[NUM_AXES-1:0];
				CFG_AMASS_ONE:   thr_one_q   <= cfg_data;
				CFG_AMASS_TWO:   thr_two_q   <= cfg_data;
				CFG_AMASS_THREE: thr_three_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid <= 1'b0;
		else if (!in_stall)
			s1_valid <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			s1_opcode  <= opcode;
			s1_slot    <= slot;
			s1_event   <= event_count;
			s1_axis[0] <= axis_zero_steps;
			s1_axis[1] <= axis_one_steps;
			s1_axis[2] <= axis_two_steps;
			s1_dir     <= axis_dir_bits;
			s1_steps   <= segment_steps;
			s1_cycles  <= step_cycles;
		end
	end

	// command decode
	assign is_tick = done && (s1_opcode == OP_TICK);
	assign is_load = done && (s1_opcode == OP_LOAD);
	assign is_push = done && (s1_opcode == OP_PUSH);
	assign rej     = is_push && ring_stat.full;
	assign push_en = is_push && !ring_stat.full;

	// tick: when idle, pop a segment from a non-empty ring or stop on an empty one
	assign pop     = is_tick && !running_q && !ring_stat.empty;
	assign stop    = is_tick && !running_q && ring_stat.empty;
	assign go      = is_tick && (running_q || !ring_stat.empty);
	assign seed    = pop && (cur_slot_q != tail_seg.slot);
	assign rd_slot = pop ? tail_seg.slot : cur_slot_q;

	// segment length, a zero-step segment still ends after one tick
	assign steps_cur = pop ? tail_seg.n_step : steps_left_q;
	assign steps_dec = (steps_cur != '0) ? steps_cur - STEPS_W'(1) : '0;
	assign seg_end   = (steps_dec == '0);

	assign axis_ctrl.go       = go;
	assign axis_ctrl.seed     = seed;
	assign axis_ctrl.load_inc = pop;

	always_comb begin
		for (int i = 0; i < NUM_AXES; i++)
			inc_new[i] = blk_axis[i] >> tail_seg.level;
	end

	bspg_ring #(
		.RING_DEPTH (RING_DEPTH)
	) u_ring (
		.clk           (clk),
		.arst_n        (arst_n),
		.push_en       (push_en),
		.pop_en        (go && seg_end),
		.step_cycles   (s1_cycles),
		.segment_steps (s1_steps),
		.slot          (s1_slot),
		.thr_one       (thr_one_q),
		.thr_two       (thr_two_q),
		.thr_three     (thr_three_q),
		.stat          (ring_stat),
		.tail_seg      (tail_seg)
	);

	bspg_blocks u_blocks (
		.clk      (clk),
		.load_en  (is_load),
		.wr_slot  (s1_slot),
		.wr_event (s1_event),
		.wr_axis  (s1_axis),
		.wr_dir   (s1_dir),
		.rd_slot  (rd_slot),
		.rd_event (blk_event),
		.rd_axis  (blk_axis),
		.rd_dir   (blk_dir)
	);

	for (genvar g = 0; g < NUM_AXES; g++) begin : g_axis
		bspg_axis u_axis (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (axis_ctrl),
			.seed_val  (blk_event >> 1),
			.inc_new   (inc_new[g]),
			.event_val (blk_event),
			.dir_neg   (blk_dir[g]),
			.step      (step_raw[g]),
			.pos_nxt   (pos_nxt[g])
		);
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q    <= 1'b0;
			cur_slot_q   <= '0;
			steps_left_q <= '0;
			pend_step_q  <= '0;
			pend_dir_q   <= '0;
		end else begin
			if (pop) begin
				cur_slot_q <= tail_seg.slot;
				pend_dir_q <= blk_dir ^ dir_inv_q;
			end
			if (go) begin
				running_q    <= !seg_end;
				steps_left_q <= steps_dec;
				pend_step_q  <= step_raw ^ step_inv_q;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (advance)
			out_valid <= s1_valid;
	end

	always_ff @(posedge clk) begin
		if (done) begin
			step_bits     <= pend_step_q;
			dir_bits      <= pend_dir_q;
			timer_period  <= pop ? tail_seg.period : '0;
			period_valid  <= pop;
			cycle_stop    <= stop;
			rejected      <= rej;
			position_zero <= pos_nxt[0];
			position_one  <= pos_nxt[1];
			position_two  <= pos_nxt[2];
		end
	end

	// a running segment always has its entry still in the ring
	a_running_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		running_q |-> !ring_stat.empty)
		else $error("segment running with empty ring");

	// a result flags at most one of pop, stop and reject
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ($countones({period_valid, cycle_stop, rejected}) <= 1))
		else $error("conflicting result flags");

	// an idle tick leaves the sequencer idle
	a_stop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		stop |=> !running_q)
		else $error("sequencer running after stop");

	// a pop only happens on a tick that finds the sequencer idle
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> is_tick && !running_q)
		else $error("pop while segment running");

endmodule

@@ sv/bspg_ring.sv @@
module bspg_ring #(
	parameter int RING_DEPTH = bspg_pkg::RING_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push_en,
	input  logic                               pop_en,
	input  logic [bspg_pkg::CYCLES_W-1:0]      step_cycles,
	input  logic [bspg_pkg::STEPS_W-1:0]       segment_steps,
	input  logic [bspg_pkg::SLOT_W-1:0]        slot,
	input  logic [bspg_pkg::CYCLES_W-1:0]      thr_one,
	input  logic [bspg_pkg::CYCLES_W-1:0]      thr_two,
	input  logic [bspg_pkg::CYCLES_W-1:0]      thr_three,
	output bspg_pkg::ring_stat_t               stat,
	output bspg_pkg::seg_t                     tail_seg
);
	import bspg_pkg::*;

	localparam int PTR_W = $clog2(RING_DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

	seg_t             ring_mem [RING_DEPTH];
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [PTR_W-1:0] head_inc;
	logic [PTR_W-1:0] tail_inc;
	logic [PTR_W-1:0] tail_nxt;
	logic [LEVEL_W-1:0] level;
	logic [CYCLES_W-1:0] cyc_sh;
	seg_t             wr_seg;
	seg_t             rd_q;

	// pointer wrap
	assign head_inc = (head_q == PTR_LAST) ? '0 : head_q + PTR_W'(1);
	assign tail_inc = (tail_q == PTR_LAST) ? '0 : tail_q + PTR_W'(1);
	assign tail_nxt = pop_en ? tail_inc : tail_q;

	assign stat.empty = (head_q == tail_q);
	assign stat.full  = (head_inc == tail_q);

	// smoothing level, checked in threshold order
	always_comb begin
		if (step_cycles < thr_one)
			level = 2'd0;
		else if (step_cycles < thr_two)
			level = 2'd1;
		else if (step_cycles < thr_three)
			level = 2'd2;
		else
			level = 2'd3;
	end

	// shifted period with saturation, shifted step count wraps
	always_comb begin
		cyc_sh         = step_cycles >> level;
		wr_seg.period  = (cyc_sh[CYCLES_W-1:STEPS_W] != '0) ? PERIOD_MAX : cyc_sh[STEPS_W-1:0];
		wr_seg.n_step  = segment_steps << level;
		wr_seg.level   = level;
		wr_seg.slot    = slot;
	end

	// head and tail pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else begin
			if (push_en)
				head_q <= head_inc;
			tail_q <= tail_nxt;
		end
	end

	// ring storage, registered read of the next tail with write bypass
	always_ff @(posedge clk) begin
		if (push_en)
			ring_mem[head_q] <= wr_seg;
		if (push_en && (head_q == tail_nxt))
			rd_q <= wr_seg;
		else
			rd_q <= ring_mem[tail_nxt];
	end

	assign tail_seg = rd_q;

endmodule

@@ sv/bspg_blocks.sv @@
module bspg_blocks (
	input  logic                                                    clk,
	input  logic                                                    load_en,
	input  logic [bspg_pkg::SLOT_W-1:0]                             wr_slot,
	input  logic [bspg_pkg::EVENT_W-1:0]                            wr_event,
	input  logic [bspg_pkg::NUM_AXES-1:0][bspg_pkg::EVENT_W-1:0]    wr_axis,
	input  logic [bspg_pkg::NUM_AXES-1:0]                           wr_dir,
	input  logic [bspg_pkg::SLOT_W-1:0]                             rd_slot,
	output logic [bspg_pkg::BLK_W-1:0]                              rd_event,
	output logic [bspg_pkg::NUM_AXES-1:0][bspg_pkg::BLK_W-1:0]      rd_axis,
	output logic [bspg_pkg::NUM_AXES-1:0]                           rd_dir
);
	import bspg_pkg::*;

	localparam logic [SLOT_W-1:0] SLOT_LIMIT = SLOT_W'(BLOCK_SLOTS);

	logic [BLK_W-1:0]                    event_tbl [BLOCK_SLOTS];
	logic [NUM_AXES-1:0][BLK_W-1:0]      axis_tbl  [BLOCK_SLOTS];
	logic [NUM_AXES-1:0]                 dir_tbl   [BLOCK_SLOTS];
	logic                                rd_ok;

	// block load, counts scaled by the smoothing shift
	always_ff @(posedge clk) begin
		if (load_en && (wr_slot < SLOT_LIMIT)) begin
			event_tbl[wr_slot] <= {wr_event, SMOOTH_SHIFT'(0)};
			for (int i = 0; i < NUM_AXES; i++)
				axis_tbl[wr_slot][i] <= {wr_axis[i], SMOOTH_SHIFT'(0)};
			dir_tbl[wr_slot] <= wr_dir;
		end
	end

	// the slot past the table reads as an empty block
	assign rd_ok    = (rd_slot < SLOT_LIMIT);
	assign rd_event = rd_ok ? event_tbl[rd_slot] : '0;
	assign rd_axis  = rd_ok ? axis_tbl[rd_slot]  : '0;
	assign rd_dir   = rd_ok ? dir_tbl[rd_slot]   : '0;

endmodule

@@ sv/bspg_axis.sv @@
module bspg_axis (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bspg_pkg::axis_ctrl_t          ctrl,
	input  logic [bspg_pkg::BLK_W-1:0]    seed_val,
	input  logic [bspg_pkg::BLK_W-1:0]    inc_new,
	input  logic [bspg_pkg::BLK_W-1:0]    event_val,
	input  logic                          dir_neg,
	output logic                          step,
	output logic [bspg_pkg::POS_W-1:0]    pos_nxt
);
	import bspg_pkg::*;

	logic [ACC_W-1:0] acc_q;
	logic [BLK_W-1:0] inc_q;
	logic [POS_W-1:0] pos_q;
	logic [ACC_W-1:0] acc_base;
	logic [BLK_W-1:0] inc_cur;
	logic [ACC_W-1:0] sum;
	logic [ACC_W-1:0] ev_ext;
	logic [ACC_W-1:0] acc_nxt;

	// bresenham add, compare and subtract
	always_comb begin
		acc_base = ctrl.seed ? ACC_W'(seed_val) : acc_q;
		inc_cur  = ctrl.load_inc ? inc_new : inc_q;
		ev_ext   = ACC_W'(event_val);
		sum      = acc_base + ACC_W'(inc_cur);
		step     = ctrl.go && (sum > ev_ext);
		acc_nxt  = (sum > ev_ext) ? sum - ev_ext : sum;
		if (step)
			pos_nxt = dir_neg ? pos_q - POS_W'(1) : pos_q + POS_W'(1);
		else
			pos_nxt = pos_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			inc_q <= '0;
			pos_q <= '0;
		end else if (ctrl.go) begin
			acc_q <= acc_nxt;
			inc_q <= inc_cur;
			pos_q <= pos_nxt;
		end
	end

endmodule

@@ tb/sv/tb_bresenham_step_pulse_generator_unit.sv @@
`timescale 1ns / 100ps

module tb_bresenham_step_pulse_generator_unit;
	import bspg_pkg::*;

	localparam int RING           = RING_DEPTH_DEF;
	localparam int RANDOM_BEATS   = 950;
	localparam int PHASES         = 4;
	localparam int CYCLE_LIMIT    = 400000;
	localparam int HOLDOFF_AT     = 620;
	localparam int HOLDOFF_CYCLES = 60;
	localparam int QUIET_FROM     = 400;
	localparam int QUIET_TO       = 700;
	localparam bit [1:0] OP_NOP   = 2'd3;

	// one command beat as offered on the input channel
	typedef struct packed {
		bit [1:0]          op;
		bit [SLOT_W-1:0]   slot;
		bit [EVENT_W-1:0]  events;
		bit [EVENT_W-1:0]  ax0;
		bit [EVENT_W-1:0]  ax1;
		bit [EVENT_W-1:0]  ax2;
		bit [NUM_AXES-1:0] dirs;
		bit [STEPS_W-1:0]  nsteps;
		bit [CYCLES_W-1:0] cycles;
	} command_t;

	// one result beat
	typedef struct packed {
		bit [NUM_AXES-1:0] step;
		bit [NUM_AXES-1:0] dir;
		bit [STEPS_W-1:0]  period;
		bit                pvalid;
		bit                stop;
		bit                rej;
		bit [POS_W-1:0]    pos0;
		bit [POS_W-1:0]    pos1;
		bit [POS_W-1:0]    pos2;
	} pulse_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] opcode = '0;
	logic [SLOT_W-1:0] slot = '0;
	logic [EVENT_W-1:0] event_count = '0;
	logic [EVENT_W-1:0] axis_zero_steps = '0;
	logic [EVENT_W-1:0] axis_one_steps = '0;
	logic [EVENT_W-1:0] axis_two_steps = '0;
	logic [NUM_AXES-1:0] axis_dir_bits = '0;
	logic [STEPS_W-1:0] segment_steps = '0;
	logic [CYCLES_W-1:0] step_cycles = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [NUM_AXES-1:0] step_bits;
	logic [NUM_AXES-1:0] dir_bits;
	logic [STEPS_W-1:0] timer_period;
	logic period_valid;
	logic cycle_stop;
	logic rejected;
	logic signed [POS_W-1:0] position_zero;
	logic signed [POS_W-1:0] position_one;
	logic signed [POS_W-1:0] position_two;

	bresenham_step_pulse_generator_unit u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.opcode         (opcode),
		.slot           (slot),
		.event_count    (event_count),
		.axis_zero_steps(axis_zero_steps),
		.axis_one_steps (axis_one_steps),
		.axis_two_steps (axis_two_steps),
		.axis_dir_bits  (axis_dir_bits),
		.segment_steps  (segment_steps),
		.step_cycles    (step_cycles),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.step_bits      (step_bits),
		.dir_bits       (dir_bits),
		.timer_period   (timer_period),
		.period_valid   (period_valid),
		.cycle_stop     (cycle_stop),
		.rejected       (rejected),
		.position_zero  (position_zero),
		.position_one   (position_one),
		.position_two   (position_two)
	);

	// clock
	always #10 clk = ~clk;

	// shadow of the stepper state and its settings
	bit [BLK_W-1:0]    slot_event_len [BLOCK_SLOTS];
	bit [BLK_W-1:0]    slot_axis_len [BLOCK_SLOTS][NUM_AXES];
	bit [NUM_AXES-1:0] slot_neg_dirs [BLOCK_SLOTS];
	seg_t              seg_fifo [RING];
	int                seg_wr = 0;
	int                seg_rd = 0;
	bit                seg_active = 1'b0;
	bit [SLOT_W-1:0]   active_slot = '0;
	bit [LEVEL_W-1:0]  active_level = '0;
	bit [STEPS_W-1:0]  ticks_left = '0;
	bit [ACC_W-1:0]    bres_acc [NUM_AXES];
	bit [BLK_W-1:0]    bres_inc [NUM_AXES];
	bit [NUM_AXES-1:0] held_step = '0;
	bit [NUM_AXES-1:0] held_dir = '0;
	bit [POS_W-1:0]    axis_pos [NUM_AXES];
	bit [NUM_AXES-1:0] dir_flip = DIR_INV_RST;
	bit [NUM_AXES-1:0] step_flip = STEP_INV_RST;
	bit [CYCLES_W-1:0] amass_th [3] = '{AMASS_ONE_RST, AMASS_TWO_RST, AMASS_THREE_RST};

	command_t      command_backlog [$];
	pulse_result_t results_due [$];
	command_t      drv_cmd;
	bit            drv_busy = 1'b0;
	int            beats_taken = 0;
	int            cycle_count = 0;
	int            mismatches = 0;
	int            holdoff_left = 0;
	bit            holdoff_done = 1'b0;

	// slot seven reads as an empty block
	function automatic bit [BLK_W-1:0] block_events(input bit [SLOT_W-1:0] s);
		return (s < BLOCK_SLOTS) ? slot_event_len[s] : '0;
	endfunction

	function automatic bit [BLK_W-1:0] block_axis(input bit [SLOT_W-1:0] s, input int a);
		return (s < BLOCK_SLOTS) ? slot_axis_len[s][a] : '0;
	endfunction

	function automatic bit [NUM_AXES-1:0] block_dirs(input bit [SLOT_W-1:0] s);
		return (s < BLOCK_SLOTS) ? slot_neg_dirs[s] : '0;
	endfunction

	// apply one command to the shadow state, return the beat it must produce
	function automatic pulse_result_t advance_stepper(input command_t c);
		pulse_result_t r;
		seg_t seg;
		bit [CYCLES_W-1:0] cyc;
		bit [STEPS_W-1:0] n;
		bit [LEVEL_W-1:0] lvl;
		bit [ACC_W-1:0] ev;
		bit [NUM_AXES-1:0] bdir;
		bit [NUM_AXES-1:0] sb;
		bit go;
		int nxt;
		r = '0;
		r.step = held_step;
		r.dir = held_dir;
		case (c.op)
			OP_LOAD: begin
				if (c.slot < BLOCK_SLOTS) begin
					slot_event_len[c.slot] = {c.events, 3'b000};
					slot_axis_len[c.slot][0] = {c.ax0, 3'b000};
					slot_axis_len[c.slot][1] = {c.ax1, 3'b000};
					slot_axis_len[c.slot][2] = {c.ax2, 3'b000};
					slot_neg_dirs[c.slot] = c.dirs;
				end
			end
			OP_PUSH: begin
				nxt = (seg_wr + 1) % RING;
				if (nxt == seg_rd) begin
					r.rej = 1'b1;
				end else begin
					cyc = c.cycles;
					if (cyc < amass_th[0]) lvl = 0;
					else if (cyc < amass_th[1]) lvl = 1;
					else if (cyc < amass_th[2]) lvl = 2;
					else lvl = 3;
					cyc = cyc >> lvl;
					n = c.nsteps << lvl;
					seg.n_step = n;
					seg.period = (cyc < 32'h10000) ? cyc[STEPS_W-1:0] : PERIOD_MAX;
					seg.level = lvl;
					seg.slot = c.slot;
					seg_fifo[seg_wr] = seg;
					seg_wr = nxt;
				end
			end
			OP_TICK: begin
				go = 1'b1;
				// start the next queued segment
				if (!seg_active) begin
					if (seg_wr != seg_rd) begin
						seg = seg_fifo[seg_rd];
						seg_active = 1'b1;
						r.period = seg.period;
						r.pvalid = 1'b1;
						ticks_left = seg.n_step;
						active_level = seg.level;
						if (active_slot != seg.slot) begin
							active_slot = seg.slot;
							for (int i = 0; i < NUM_AXES; i++)
								bres_acc[i] = block_events(active_slot) >> 1;
						end
						held_dir = block_dirs(active_slot) ^ dir_flip;
						for (int i = 0; i < NUM_AXES; i++)
							bres_inc[i] = block_axis(active_slot, i) >> active_level;
					end else begin
						r.stop = 1'b1;
						go = 1'b0;
					end
				end
				// bresenham update per axis
				if (go) begin
					ev = block_events(active_slot);
					bdir = block_dirs(active_slot);
					sb = '0;
					for (int i = 0; i < NUM_AXES; i++) begin
						bres_acc[i] = bres_acc[i] + bres_inc[i];
						if (bres_acc[i] > ev) begin
							bres_acc[i] = bres_acc[i] - ev;
							sb[i] = 1'b1;
							if (bdir[i]) axis_pos[i] = axis_pos[i] - 1;
							else axis_pos[i] = axis_pos[i] + 1;
						end
					end
					if (ticks_left != 0) ticks_left = ticks_left - 1;
					if (ticks_left == 0) begin
						seg_active = 1'b0;
						seg_rd = (seg_rd + 1) % RING;
					end
					held_step = sb ^ step_flip;
				end
			end
			default: ;
		endcase
		r.pos0 = axis_pos[0];
		r.pos1 = axis_pos[1];
		r.pos2 = axis_pos[2];
		return r;
	endfunction

	function automatic command_t make_cmd(input bit [1:0] op, input bit [SLOT_W-1:0] s,
			input bit [EVENT_W-1:0] ev, input bit [EVENT_W-1:0] a0,
			input bit [EVENT_W-1:0] a1, input bit [EVENT_W-1:0] a2,
			input bit [NUM_AXES-1:0] d, input bit [STEPS_W-1:0] n,
			input bit [CYCLES_W-1:0] cyc);
		command_t c;
		c.op = op;
		c.slot = s;
		c.events = ev;
		c.ax0 = a0;
		c.ax1 = a1;
		c.ax2 = a2;
		c.dirs = d;
		c.nsteps = n;
		c.cycles = cyc;
		return c;
	endfunction

	// random command, mostly ticks and short segments so the ring keeps turning
	function automatic command_t random_cmd();
		command_t c;
		bit [6*32-1:0] raw;
		int roll;
		int kind;
		raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
		c = raw[$bits(command_t)-1:0];
		roll = $urandom_range(0, 99);
		if (roll < 56) begin
			c.op = OP_TICK;
		end else if (roll < 78) begin
			c.op = OP_PUSH;
			c.slot = ($urandom_range(0, 19) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
			kind = $urandom_range(0, 19);
			if (kind == 0) c.nsteps = '0;
			else if (kind == 1) c.nsteps = 16'($urandom_range(16, 60));
			else c.nsteps = 16'($urandom_range(1, 6));
			kind = $urandom_range(0, 9);
			if (kind == 0) c.cycles = $urandom();
			else if (kind <= 3) c.cycles = amass_th[kind-1] + $urandom_range(0, 2) - 1;
			else c.cycles = $urandom_range(0, 45000);
		end else if (roll < 96) begin
			c.op = OP_LOAD;
			c.slot = ($urandom_range(0, 19) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
			kind = $urandom_range(0, 9);
			// leave the random wide counts alone on the first kind
			if (kind != 0) begin
				c.events = (kind == 1) ? '0 : 28'($urandom_range(1, 64));
				c.ax0 = 28'($urandom_range(0, c.events + 1));
				c.ax1 = 28'($urandom_range(0, c.events + 1));
				c.ax2 = 28'($urandom_range(0, c.events));
			end
		end else begin
			c.op = OP_NOP;
		end
		return c;
	endfunction

	function automatic bit idle_now();
		return (cycle_count < QUIET_FROM || cycle_count >= QUIET_TO) &&
			($urandom_range(0, 99) < 7);
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// register write, issued at a falling edge and held for one cycle
	task automatic cfg_write(input cfg_idx_t idx, input bit [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			CFG_DIR_INV:     dir_flip = data[NUM_AXES-1:0];
			CFG_STEP_INV:    step_flip = data[NUM_AXES-1:0];
			CFG_AMASS_ONE:   amass_th[0] = data;
			CFG_AMASS_TWO:   amass_th[1] = data;
			CFG_AMASS_THREE: amass_th[2] = data;
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic wait_idle();
		while (command_backlog.size() != 0 || drv_busy || results_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// cycle counter and watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// command beat taken: predict its result
	always @(posedge clk) begin
		if (arst_n && in_valid && in_stall === 1'b0) begin
			results_due.push_back(advance_stepper(drv_cmd));
			drv_busy = 1'b0;
			beats_taken++;
		end
	end

	// command driver
	always @(negedge clk) begin
		if (arst_n && !drv_busy) begin
			if (command_backlog.size() != 0 && !idle_now()) begin
				drv_cmd = command_backlog.pop_front();
				drv_busy = 1'b1;
				in_valid <= 1'b1;
				opcode <= drv_cmd.op;
				slot <= drv_cmd.slot;
				event_count <= drv_cmd.events;
				axis_zero_steps <= drv_cmd.ax0;
				axis_one_steps <= drv_cmd.ax1;
				axis_two_steps <= drv_cmd.ax2;
				axis_dir_bits <= drv_cmd.dirs;
				segment_steps <= drv_cmd.nsteps;
				step_cycles <= drv_cmd.cycles;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result stall: random, plus one long hold-off to back the block up
	always @(negedge clk) begin
		if (!holdoff_done && beats_taken >= HOLDOFF_AT) begin
			holdoff_left = HOLDOFF_CYCLES;
			holdoff_done = 1'b1;
		end
		if (holdoff_left != 0) begin
			holdoff_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= idle_now();
		end
	end

	// result beat check against the oldest prediction
	always @(posedge clk) begin : result_check
		pulse_result_t want;
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			if (results_due.size() == 0) begin
				$display("%0t: result beat with no command outstanding", $time);
				mismatches++;
			end else begin
				want = results_due.pop_front();
				check_field("step_bits", want.step, step_bits);
				check_field("dir_bits", want.dir, dir_bits);
				check_field("timer_period", want.period, timer_period);
				check_field("period_valid", want.pvalid, period_valid);
				check_field("cycle_stop", want.stop, cycle_stop);
				check_field("rejected", want.rej, rejected);
				check_field("position_zero", want.pos0, position_zero);
				check_field("position_one", want.pos1, position_one);
				check_field("position_two", want.pos2, position_two);
			end
		end
	end

	initial begin : stimulus
		bit [NUM_AXES-1:0] dmask;
		bit [NUM_AXES-1:0] smask;
		bit [CYCLES_W-1:0] t1;
		bit [CYCLES_W-1:0] t2;
		bit [CYCLES_W-1:0] t3;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int p = 0; p < PHASES; p++) begin
			wait_idle();
			case (p)
				0: begin
					dmask = DIR_INV_RST;
					smask = STEP_INV_RST;
					t1 = AMASS_ONE_RST;
					t2 = AMASS_TWO_RST;
					t3 = AMASS_THREE_RST;
				end
				// every cycle count lands on the top smoothing level
				1: begin
					dmask = 3'b111;
					smask = 3'b000;
					t1 = '0;
					t2 = '0;
					t3 = '0;
				end
				// only the largest cycle count leaves level zero
				2: begin
					dmask = 3'b101;
					smask = 3'b010;
					t1 = '1;
					t2 = '1;
					t3 = '1;
				end
				default: begin
					dmask = 3'($urandom_range(0, 7));
					smask = 3'($urandom_range(0, 7));
					t1 = $urandom_range(1, 20000);
					t2 = t1 + $urandom_range(0, 20000);
					t3 = t2 + $urandom_range(0, 40000);
				end
			endcase
			cfg_write(CFG_DIR_INV, ($urandom() << 3) | dmask);
			cfg_write(CFG_STEP_INV, ($urandom() << 3) | smask);
			cfg_write(CFG_AMASS_ONE, t1);
			cfg_write(CFG_AMASS_TWO, t2);
			cfg_write(CFG_AMASS_THREE, t3);
			cfg_we <= 1'b0;

			if (p == 0) begin
				// tick on an empty ring, then fill every slot of the block table
				command_backlog.push_back(make_cmd(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
				command_backlog.push_back(make_cmd(OP_LOAD, 0, 8, 8, 4, 0, 3'b000, 0, 0));
				command_backlog.push_back(make_cmd(OP_LOAD, 1, '1, '1, 0, 1, 3'b111, 0, 0));
				command_backlog.push_back(make_cmd(OP_LOAD, 2, 0, 0, 0, 0, 3'b010, 0, 0));
				command_backlog.push_back(make_cmd(OP_LOAD, 3, 5, 3, 5, 2, 3'b101, 0, 0));
				command_backlog.push_back(make_cmd(OP_LOAD, 4, 3, 7, 1, 2, 3'b011, 0, 0));
				command_backlog.push_back(make_cmd(OP_LOAD, 5, 100, 100, 50, 33, 3'b110, 0, 0));
				command_backlog.push_back(make_cmd(OP_LOAD, 6, 1, 1, 0, 1, 3'b001, 0, 0));
				// load into slot seven is dropped, opcode three does nothing
				command_backlog.push_back(make_cmd(OP_LOAD, 7, '1, '1, '1, '1, '1, '1, '1));
				command_backlog.push_back(make_cmd(OP_NOP, '1, '1, '1, '1, '1, '1, '1, '1));
				// first segment on slot zero keeps the counters unseeded
				command_backlog.push_back(make_cmd(OP_PUSH, 0, 0, 0, 0, 0, 0, 2, 0));
				command_backlog.push_back(make_cmd(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
				command_backlog.push_back(make_cmd(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
				// fill the ring across all levels, slot seven, zero steps, wrap and saturation
				command_backlog.push_back(make_cmd(OP_PUSH, 7, 0, 0, 0, 0, 0, 1, 9000));
				command_backlog.push_back(make_cmd(OP_PUSH, 3, 0, 0, 0, 0, 0, 0, 20000));
				command_backlog.push_back(make_cmd(OP_PUSH, 5, 0, 0, 0, 0, 0, 16'h2001, '1));
				command_backlog.push_back(make_cmd(OP_PUSH, 1, 0, 0, 0, 0, 0, 3, 35999));
				command_backlog.push_back(make_cmd(OP_PUSH, 6, 0, 0, 0, 0, 0, 1, 8999));
				command_backlog.push_back(make_cmd(OP_PUSH, 4, 0, 0, 0, 0, 0, 2, 18000));
				command_backlog.push_back(make_cmd(OP_PUSH, 2, 0, 0, 0, 0, 0, 1, 36000));
				// ring full
				command_backlog.push_back(make_cmd(OP_PUSH, 3, 0, 0, 0, 0, 0, '1, '1));
				repeat (4)
					command_backlog.push_back(make_cmd(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0));
			end

			for (int n = 0; n < RANDOM_BEATS / PHASES; n++)
				command_backlog.push_back(random_cmd());
		end

		wait_idle();
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
